@@ design/jps_pkg.sv @@
package jps_pkg;

    // channel count and widths
    localparam int MAX_CHANNELS     = 2;
    localparam int CHANNELS_DEFAULT = 2;
    localparam int SAMPLE_W         = 16;
    localparam int GAIN_W           = 16;
    localparam int ACC_W            = 28;
    localparam int SEG_W            = 3;
    localparam int NUM_SEGS         = 6;
    localparam int NUM_COEFS        = 4;
    localparam int GAIN_FRAC        = 12;
    localparam int HORNER_SHIFT     = 15;
    localparam int OUT_SHIFT        = 7;

    // pipeline depth of one lane, and of the whole block including the merge register
    localparam int LANE_LATENCY   = 6;
    localparam int RESULT_LATENCY = LANE_LATENCY + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic [SEG_W-1:0]           seg_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // what travels between the horner steps of a lane
    typedef struct packed {
        acc_t    acc;
        sample_t v;
        seg_t    seg;
    } lane_state_t;

    localparam gain_t GAIN_RESET = 16'd2048;

    // segment codes beyond the six cubics
    localparam seg_t SEG_CLAMP_LOW  = 3'd6;
    localparam seg_t SEG_CLAMP_HIGH = 3'd7;

    localparam sample_t SAMPLE_MIN = -16'sd32768;
    localparam sample_t SAMPLE_MAX = 16'sd32767;

    // output of the low clamp, used by the checks
    localparam sample_t CLAMP_LOW_OUT = 16'sd18682;

    // upper edge of each cubic segment, Q1.15
    localparam sample_t SEG_LIMIT [NUM_SEGS] = '{
        -16'sd23774, -16'sd7990, 16'sd15930, 16'sd23999, 16'sd30527, 16'sd32713
    };

    // c3, c2, c1, c0 per segment, Q6.22; the clamps are rows with only c0 set
    localparam acc_t COEF [8][NUM_COEFS] = '{
        '{ 28'sd6950,     28'sd20851,     28'sd2273858,   -28'sd132792  },
        '{ 28'sd379819,   28'sd832402,    28'sd2862696,   28'sd9605     },
        '{ -28'sd1239249, -28'sd351852,   28'sd2573919,   -28'sd13862   },
        '{ -28'sd112156,  -28'sd1995650,  28'sd3373059,   -28'sd143366  },
        '{ 28'sd6042734,  -28'sd15518925, 28'sd13277489,  -28'sd2561378 },
        '{ -28'sd6841329, 28'sd20490014,  -28'sd20268974, 28'sd7855931  },
        '{ 28'sd0,        28'sd0,         28'sd0,         -28'sd2391286 },
        '{ 28'sd0,        28'sd0,         28'sd0,         28'sd1233335  }
    };

    // pick the segment of a scaled sample
    function automatic seg_t seg_select(sample_t v);
        seg_t s;
        s = SEG_CLAMP_HIGH;
        for (int k = NUM_SEGS - 1; k >= 0; k--) begin
            if (v <= SEG_LIMIT[k]) begin
                s = seg_t'(k);
            end
        end
        if (v == SAMPLE_MIN) begin
            s = SEG_CLAMP_LOW;
        end
        return s;
    endfunction

endpackage

@@ design/jps_horner.sv @@
module jps_horner #(
    parameter int STEP = 1
) (
    input  logic                    clk,
    input  jps_pkg::lane_state_t    state_in,
    output jps_pkg::lane_state_t    state_out
);

    localparam int PROD_W = jps_pkg::ACC_W + jps_pkg::SAMPLE_W;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_shifted;
    jps_pkg::acc_t            acc_next;
    jps_pkg::lane_state_t     state_reg;

    // acc * x / 2^22 with x = v * 2^7, then add the next coefficient
    always_comb
    begin
        prod         = PROD_W'(state_in.acc) * PROD_W'(state_in.v);
        prod_shifted = prod >>> jps_pkg::HORNER_SHIFT;
        acc_next     = jps_pkg::acc_t'(prod_shifted[jps_pkg::ACC_W-1:0])
                       + jps_pkg::COEF[state_in.seg][STEP];
    end

    // step register
    always_ff @(posedge clk)
    begin
        state_reg.acc <= acc_next;
        state_reg.v   <= state_in.v;
        state_reg.seg <= state_in.seg;
    end

    assign state_out = state_reg;

endmodule

@@ design/jps_lane.sv @@
module jps_lane (
    input  logic             clk,
    input  jps_pkg::sample_t sample,
    input  jps_pkg::gain_t   gain,
    output jps_pkg::sample_t shaped
);

    localparam int PROD_W = jps_pkg::SAMPLE_W + jps_pkg::GAIN_W + 1;
    localparam int OUT_W  = jps_pkg::ACC_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] scaled;
    jps_pkg::sample_t         v_sat;
    jps_pkg::seg_t            seg_sel;
    jps_pkg::lane_state_t     first_reg;
    jps_pkg::lane_state_t     step1;
    jps_pkg::lane_state_t     step2;
    jps_pkg::lane_state_t     step3;
    logic signed [OUT_W-1:0]  neg_round;
    logic signed [OUT_W-1:0]  out_shifted;
    jps_pkg::sample_t         y_sat;
    jps_pkg::sample_t         shaped_reg;

    // gain multiply
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(sample) * $signed({1'b0, gain});
    end

    // floor to Q1.15 with saturation, then segment lookup
    always_comb
    begin
        scaled = prod_reg >>> jps_pkg::GAIN_FRAC;
        if (scaled > PROD_W'(jps_pkg::SAMPLE_MAX)) begin
            v_sat = jps_pkg::SAMPLE_MAX;
        end else if (scaled < PROD_W'(jps_pkg::SAMPLE_MIN)) begin
            v_sat = jps_pkg::SAMPLE_MIN;
        end else begin
            v_sat = jps_pkg::sample_t'(scaled[jps_pkg::SAMPLE_W-1:0]);
        end
        seg_sel = jps_pkg::seg_select(v_sat);
    end

    // horner start value is c3
    always_ff @(posedge clk)
    begin
        first_reg.acc <= jps_pkg::COEF[seg_sel][0];
        first_reg.v   <= v_sat;
        first_reg.seg <= seg_sel;
    end

    jps_horner #(.STEP(1)) u_step1 (.clk(clk), .state_in(first_reg), .state_out(step1));
    jps_horner #(.STEP(2)) u_step2 (.clk(clk), .state_in(step1), .state_out(step2));
    jps_horner #(.STEP(3)) u_step3 (.clk(clk), .state_in(step2), .state_out(step3));

    // negate, round to nearest with ties up, saturate
    always_comb
    begin
        neg_round   = -OUT_W'(step3.acc) + OUT_W'(64);
        out_shifted = neg_round >>> jps_pkg::OUT_SHIFT;
        if (out_shifted > OUT_W'(jps_pkg::SAMPLE_MAX)) begin
            y_sat = jps_pkg::SAMPLE_MAX;
        end else if (out_shifted < OUT_W'(jps_pkg::SAMPLE_MIN)) begin
            y_sat = jps_pkg::SAMPLE_MIN;
        end else begin
            y_sat = jps_pkg::sample_t'(out_shifted[jps_pkg::SAMPLE_W-1:0]);
        end
    end

    // output stage
    always_ff @(posedge clk)
    begin
        shaped_reg <= y_sat;
    end

    assign shaped = shaped_reg;

endmodule

@@ design/jps_merge.sv @@
module jps_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  jps_pkg::sample_t lane_y [jps_pkg::MAX_CHANNELS],
    output logic             done,
    output jps_pkg::sample_t left_shaped,
    output jps_pkg::sample_t right_shaped
);

    logic             done_reg;
    jps_pkg::sample_t left_reg;
    jps_pkg::sample_t right_reg;

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= valid_in;
        end
    end

    // gather the lanes into one result item
    always_ff @(posedge clk)
    begin
        left_reg  <= lane_y[0];
        right_reg <= lane_y[1];
    end

    assign done         = done_reg;
    assign left_shaped  = left_reg;
    assign right_shaped = right_reg;

endmodule

@@ design/jfet_piecewise_cubic_shaper.sv @@
// Two-channel piecewise cubic overdrive shaper. One item (a left and a right
// Q1.15 sample) is taken in every clock cycle: busy is held low, so start is
// accepted on every cycle. Each channel runs in its own fully pipelined lane
// (gain multiply, saturate and segment lookup, three Horner multiply-add
// steps, negate and round), and a merge register joins the lanes. The result
// item leaves the merge register on one cycle, marked by done;
// the receiver cannot stall, so it must take every result on that cycle.
// drive_gain may only be written while no item is in flight.
module jfet_piecewise_cubic_shaper #(
    parameter int CHANNELS = jps_pkg::CHANNELS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  jps_pkg::sample_t left_sample,
    input  jps_pkg::sample_t right_sample,
    input  logic             drive_gain_we,
    input  jps_pkg::gain_t   drive_gain_wdata,
    output logic             done,
    output jps_pkg::sample_t left_shaped,
    output jps_pkg::sample_t right_shaped
);

    localparam int LAT = jps_pkg::LANE_LATENCY;

    jps_pkg::gain_t   drive_gain_reg;
    jps_pkg::gain_t   drive_gain_next;
    logic [LAT-1:0]   valid_reg;
    logic [LAT-1:0]   valid_next;
    logic             accept;
    jps_pkg::sample_t samples [jps_pkg::MAX_CHANNELS];
    jps_pkg::sample_t lane_y  [jps_pkg::MAX_CHANNELS];

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign samples[0] = left_sample;
    assign samples[1] = right_sample;

    // gain register and item valid pipeline
    always_comb
    begin
        drive_gain_next = drive_gain_we ? drive_gain_wdata : drive_gain_reg;
        valid_next      = {valid_reg[LAT-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            drive_gain_reg <= jps_pkg::GAIN_RESET;
            valid_reg      <= '0;
        end else begin
            drive_gain_reg <= drive_gain_next;
            valid_reg      <= valid_next;
        end
    end

    // one lane per used channel, a plain delay for an unused one
    for (genvar ch = 0; ch < jps_pkg::MAX_CHANNELS; ch++) begin : g_lane
        if (ch < CHANNELS) begin : g_shape
            jps_lane u_lane (
                .clk    (clk),
                .sample (samples[ch]),
                .gain   (drive_gain_reg),
                .shaped (lane_y[ch])
            );
        end else begin : g_pass
            jps_pkg::sample_t pass_reg [LAT];
            always_ff @(posedge clk)
            begin
                pass_reg[0] <= samples[ch];
                for (int i = 1; i < LAT; i++) begin
                    pass_reg[i] <= pass_reg[i-1];
                end
            end
            assign lane_y[ch] = pass_reg[LAT-1];
        end
    end

    jps_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (valid_reg[LAT-1]),
        .lane_y       (lane_y),
        .done         (done),
        .left_shaped  (left_shaped),
        .right_shaped (right_shaped)
    );

`ifndef ASSERT_OFF
    // a result only follows an item taken exactly the pipeline depth earlier
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, jps_pkg::RESULT_LATENCY))
        else $error("result strobe without a matching item");

    // a full-scale negative sample with unity gain or more lands on the low clamp
    a_low_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && left_sample == jps_pkg::SAMPLE_MIN && drive_gain_reg >= 16'd4096)
        |-> ##7 (done && left_shaped == jps_pkg::CLAMP_LOW_OUT))
        else $error("low clamp result wrong");
`endif

endmodule
